FILE: hw/rtl/mftp_pkg.sv
`default_nettype none

package mftp_pkg;

  // Meta data bytes at an index below this are flagged as held in the buffer
  localparam int unsigned META_BUFFER_BYTES = 256;

  localparam logic [7:0] SYSEX_START  = 8'hF0;
  localparam logic [7:0] SYSEX_END    = 8'hF7;
  localparam logic [7:0] META_PREFIX  = 8'hFF;

  // Status high nibbles
  localparam logic [3:0] HI_NOTE_OFF  = 4'h8;
  localparam logic [3:0] HI_NOTE_ON   = 4'h9;
  localparam logic [3:0] HI_POLY_AT   = 4'hA;
  localparam logic [3:0] HI_CONTROL   = 4'hB;
  localparam logic [3:0] HI_PROGRAM   = 4'hC;
  localparam logic [3:0] HI_CHAN_AT   = 4'hD;
  localparam logic [3:0] HI_PITCH     = 4'hE;

  localparam logic [1:0] LEN_SHORT    = 2'd2;
  localparam logic [1:0] LEN_LONG     = 2'd3;

  // Result kinds
  localparam logic [2:0] KIND_CHANNEL   = 3'd0;
  localparam logic [2:0] KIND_SYSEX     = 3'd1;
  localparam logic [2:0] KIND_META_BYTE = 3'd2;
  localparam logic [2:0] KIND_META_END  = 3'd3;
  localparam logic [2:0] KIND_ERROR     = 3'd4;

  typedef enum logic [8:0] {
    PH_EVENT_START = 9'b000000001,
    PH_DELTA       = 9'b000000010,
    PH_EVENT_ID    = 9'b000000100,
    PH_CHANNEL     = 9'b000001000,
    PH_SYSEX       = 9'b000010000,
    PH_META_TYPE   = 9'b000100000,
    PH_META_LENGTH = 9'b001000000,
    PH_META_DATA   = 9'b010000000,
    PH_HALTED      = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       track_start;
  } item_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [31:0] delta_time;
    logic [7:0]  status_byte;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [1:0]  message_length;
    logic [7:0]  meta_kind;
    logic [31:0] meta_length;
    logic [7:0]  meta_value;
    logic [7:0]  meta_position;
    logic        meta_value_valid;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mftp_step.sv
`default_nettype none

// Parser state and per-byte decode. State moves only when advance is high.
module mftp_step import mftp_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    advance,
  input  wire item_t   item,
  output logic         res_valid,
  output result_t      res
);

  phase_t      phase, phase_next;
  logic [31:0] delta_acc, delta_acc_next;
  logic [31:0] length_acc, length_acc_next;
  logic [31:0] byte_counter, byte_counter_next;
  logic [7:0]  held_status, held_status_next;
  logic [7:0]  held_first_data, held_first_data_next;
  logic [7:0]  held_meta_kind, held_meta_kind_next;
  logic [1:0]  expected_length, expected_length_next;

  logic [7:0]  ch;
  logic [3:0]  hi;
  logic [31:0] count_inc;
  logic [31:0] idx;

  assign ch = item.data_byte;
  assign hi = item.data_byte[7:4];

  always_comb begin
    // track start resets the parser before the byte is taken
    if (item.track_start) begin
      phase_next           = PH_EVENT_START;
      delta_acc_next       = '0;
      length_acc_next      = '0;
      byte_counter_next    = '0;
      held_status_next     = '0;
      held_first_data_next = '0;
      held_meta_kind_next  = '0;
      expected_length_next = '0;
    end else begin
      phase_next           = phase;
      delta_acc_next       = delta_acc;
      length_acc_next      = length_acc;
      byte_counter_next    = byte_counter;
      held_status_next     = held_status;
      held_first_data_next = held_first_data;
      held_meta_kind_next  = held_meta_kind;
      expected_length_next = expected_length;
    end

    if (phase_next == PH_EVENT_START) begin
      delta_acc_next  = '0;
      length_acc_next = '0;
      phase_next      = PH_DELTA;
    end

    res_valid = 1'b0;
    res       = '0;
    count_inc = byte_counter_next + 32'd1;
    idx       = byte_counter_next;

    case (phase_next)
      PH_DELTA: begin
        delta_acc_next = {delta_acc_next[24:0], ch[6:0]};
        if (!ch[7]) phase_next = PH_EVENT_ID;
      end

      PH_EVENT_ID: begin
        res.delta_time = delta_acc_next;
        if (hi inside {HI_NOTE_OFF, HI_NOTE_ON, HI_POLY_AT, HI_CONTROL, HI_PITCH}) begin
          held_status_next     = ch;
          expected_length_next = LEN_LONG;
          byte_counter_next    = 32'd1;
          phase_next           = PH_CHANNEL;
        end else if (hi inside {HI_PROGRAM, HI_CHAN_AT}) begin
          held_status_next     = ch;
          expected_length_next = LEN_SHORT;
          byte_counter_next    = 32'd1;
          phase_next           = PH_CHANNEL;
        end else if (ch == SYSEX_START || ch == SYSEX_END) begin
          phase_next = PH_SYSEX;
        end else if (ch == META_PREFIX) begin
          phase_next = PH_META_TYPE;
        end else begin
          res_valid       = 1'b1;
          res.event_kind  = KIND_ERROR;
          res.status_byte = ch;
          phase_next      = PH_HALTED;
        end
      end

      PH_CHANNEL: begin
        if (byte_counter_next == 32'd1) held_first_data_next = ch;
        byte_counter_next = count_inc;
        if (count_inc == {30'd0, expected_length_next}) begin
          res_valid          = 1'b1;
          res.event_kind     = KIND_CHANNEL;
          res.delta_time     = delta_acc_next;
          res.status_byte    = held_status_next;
          res.first_data     = held_first_data_next;
          res.second_data    = (expected_length_next == LEN_LONG) ? ch : 8'd0;
          res.message_length = expected_length_next;
          phase_next         = PH_EVENT_START;
        end
      end

      PH_SYSEX: begin
        if (ch == SYSEX_END) begin
          res_valid      = 1'b1;
          res.event_kind = KIND_SYSEX;
          res.delta_time = delta_acc_next;
          phase_next     = PH_EVENT_START;
        end
      end

      PH_META_TYPE: begin
        held_meta_kind_next = ch;
        phase_next          = PH_META_LENGTH;
      end

      PH_META_LENGTH: begin
        length_acc_next = {length_acc_next[24:0], ch[6:0]};
        if (!ch[7]) begin
          if (length_acc_next == 32'd0) begin
            // empty meta event: a lone end marker
            res_valid       = 1'b1;
            res.event_kind  = KIND_META_END;
            res.delta_time  = delta_acc_next;
            res.meta_kind   = held_meta_kind_next;
            res.meta_length = length_acc_next;
            phase_next      = PH_EVENT_START;
          end else begin
            byte_counter_next = '0;
            phase_next        = PH_META_DATA;
          end
        end
      end

      PH_META_DATA: begin
        byte_counter_next    = count_inc;
        res_valid            = 1'b1;
        res.event_kind       = (count_inc == length_acc_next) ? KIND_META_END : KIND_META_BYTE;
        res.delta_time       = delta_acc_next;
        res.meta_kind        = held_meta_kind_next;
        res.meta_length      = length_acc_next;
        res.meta_value       = ch;
        res.meta_position    = idx[7:0];
        res.meta_value_valid = idx < 32'(META_BUFFER_BYTES);
        if (count_inc == length_acc_next) phase_next = PH_EVENT_START;
      end

      default: begin
        // halted: ignore bytes until the next track start
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_EVENT_START;
      delta_acc       <= '0;
      length_acc      <= '0;
      byte_counter    <= '0;
      held_status     <= '0;
      held_first_data <= '0;
      held_meta_kind  <= '0;
      expected_length <= '0;
    end else if (advance) begin
      phase           <= phase_next;
      delta_acc       <= delta_acc_next;
      length_acc      <= length_acc_next;
      byte_counter    <= byte_counter_next;
      held_status     <= held_status_next;
      held_first_data <= held_first_data_next;
      held_meta_kind  <= held_meta_kind_next;
      expected_length <= expected_length_next;
    end
  end

  a_chan_len: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.event_kind == KIND_CHANNEL)
      |-> (res.message_length == LEN_SHORT || res.message_length == LEN_LONG))
    else $error("channel result with bad length");

  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    (advance && res_valid && res.event_kind == KIND_ERROR) |=> phase == PH_HALTED)
    else $error("parser did not halt after unknown event id");

  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HALTED && !item.track_start) |-> !res_valid)
    else $error("result produced while halted");

endmodule

`default_nettype wire

FILE: hw/rtl/midi_file_track_event_parser.sv
`default_nettype none

// MIDI file track event parser. Feed the body of a track one byte per request on
// the item channel, with track_start set on the first byte of each track (this
// resets the parser before the byte is decoded). Each byte is latched into an
// input register, decoded combinationally against the parser state, and any
// result lands in an output register; one byte is taken every clock while the
// result side keeps up, and a result held by a stall holds back the next byte
// too, whether or not that byte yields a result.
// Channel messages give one result when complete, sysex gives one result at
// its F7 byte, and meta events give one result per data byte, the last flagged
// as meta end (an empty meta event gives a lone meta end). An unknown event
// byte gives an error result and the parser then ignores bytes until the next
// track start. Running status and chunk framing are not handled.
module midi_file_track_event_parser import mftp_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  // byte requests
  input  wire logic    item_valid,
  output logic         item_stall,
  input  wire item_t   item,
  // result requests
  output logic         result_valid,
  input  wire logic    result_stall,
  output result_t      result
);

  logic    in_full;
  item_t   in_item;
  logic    advance;
  logic    step_valid;
  result_t step_res;

  // the held byte is decoded once the output register is free or draining
  assign advance    = in_full && (!result_valid || !result_stall);
  assign item_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!item_stall) begin
      in_full <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      in_item <= item;
    end
  end

  mftp_step u_step (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .item      (in_item),
    .res_valid (step_valid),
    .res       (step_res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= step_valid;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_valid) begin
      result <= step_res;
    end
  end

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (!result_valid && !in_full))
    else $error("pipeline not empty after reset");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> in_full)
    else $error("input stalled with an empty input register");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result changed or dropped");

endmodule

`default_nettype wire
